[rtl/hll_pkg.sv]
// Shared types and constants of the distinct-count sketch.
// Depends on nothing; every other file imports it.
package hll_pkg;

    localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
    localparam int          MIX_SHIFT = 47;
    // Initial hash state for an 8-byte key, before the seed is mixed in.
    localparam logic [63:0] MIX_KEY8  = 64'(MIX_MUL << 3);

    localparam int FRAC_BITS = 72;
    localparam int ALPHA_W   = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int MIN_BITS  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK_OFFSET = 2'd2;

    typedef enum logic [2:0] {
        CMD_ADD      = 3'd0,
        CMD_MERGE    = 3'd1,
        CMD_WRITE    = 3'd2,
        CMD_READ     = 3'd3,
        CMD_ESTIMATE = 3'd4,
        CMD_CLEAR    = 3'd5
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_LZ,
        S_READ,
        S_MOD,
        S_SUM,
        S_DIV,
        S_FIN,
        S_CLR,
        S_DONE
    } t_state;

    function automatic logic [63:0] alpha_den(input int b);
        return 64'd10000 * (64'd1 << b) + 64'd10790;
    endfunction

    function automatic logic [63:0] alpha_num(input int b);
        return 64'd2 * 64'd7213 * (64'd1 << (b + 20)) + alpha_den(b);
    endfunction

    // Bias constant in Q0.20, rounded half up, for the larger sketch sizes.
    localparam logic [ALPHA_W-1:0] ALPHA_B7  = ALPHA_W'(alpha_num(7)  / (2 * alpha_den(7)));
    localparam logic [ALPHA_W-1:0] ALPHA_B8  = ALPHA_W'(alpha_num(8)  / (2 * alpha_den(8)));
    localparam logic [ALPHA_W-1:0] ALPHA_B9  = ALPHA_W'(alpha_num(9)  / (2 * alpha_den(9)));
    localparam logic [ALPHA_W-1:0] ALPHA_B10 = ALPHA_W'(alpha_num(10) / (2 * alpha_den(10)));
    localparam logic [ALPHA_W-1:0] ALPHA_B11 = ALPHA_W'(alpha_num(11) / (2 * alpha_den(11)));
    localparam logic [ALPHA_W-1:0] ALPHA_B12 = ALPHA_W'(alpha_num(12) / (2 * alpha_den(12)));
    localparam logic [ALPHA_W-1:0] ALPHA_B13 = ALPHA_W'(alpha_num(13) / (2 * alpha_den(13)));
    localparam logic [ALPHA_W-1:0] ALPHA_B14 = ALPHA_W'(alpha_num(14) / (2 * alpha_den(14)));
    localparam logic [ALPHA_W-1:0] ALPHA_B15 = ALPHA_W'(alpha_num(15) / (2 * alpha_den(15)));
    localparam logic [ALPHA_W-1:0] ALPHA_B16 = ALPHA_W'(alpha_num(16) / (2 * alpha_den(16)));

    function automatic logic [ALPHA_W-1:0] alpha_q20(input logic [4:0] b);
        logic [ALPHA_W-1:0] a;
        unique case (b)
            5'd4:    a = 20'd705692;
            5'd5:    a = 20'd730857;
            5'd6:    a = 20'd743440;
            5'd7:    a = ALPHA_B7;
            5'd8:    a = ALPHA_B8;
            5'd9:    a = ALPHA_B9;
            5'd10:   a = ALPHA_B10;
            5'd11:   a = ALPHA_B11;
            5'd12:   a = ALPHA_B12;
            5'd13:   a = ALPHA_B13;
            5'd14:   a = ALPHA_B14;
            5'd15:   a = ALPHA_B15;
            5'd16:   a = ALPHA_B16;
            default: a = ALPHA_B16;
        endcase
        return a;
    endfunction

endpackage

[rtl/hll_ifs.sv]
// Handshake channels of the distinct-count sketch: command items, result
// items and configuration writes. Depends on hll_pkg.
interface hll_item_if
    import hll_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [63:0] item_value;
    logic [11:0] entry_index;
    logic [7:0]  entry_data;

    modport source (output valid, cmd, item_value, entry_index, entry_data, input ready);
    modport sink   (input valid, cmd, item_value, entry_index, entry_data, output ready);
endinterface

interface hll_result_if
    import hll_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [63:0] estimate;
    logic [12:0] entry_count;

    modport source (output valid, read_data, estimate, entry_count, input ready);
    modport sink   (input valid, read_data, estimate, entry_count, output ready);
endinterface

interface hll_cfg_if
    import hll_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/hyperloglog_sketch.sv]
// Top level of the distinct-count sketch: register memory, hash sequencer,
// rank scan, estimate accumulator and divider. Depends on hll_pkg, hll_ifs.
//
//  channel    direction  carries
//  i_cfg      in         register index and write data
//  i_item     in         cmd, item_value, entry_index, entry_data
//  o_result   out        read_data, estimate, entry_count
//
// One item is worked on at a time. Merge and write read a register, then
// write the updated value back; read only reads it. Add runs the hash on the
// shared 32x32 multiplier (four 64-bit products of three partial products
// each), then the leading-zero scan (one byte a cycle), then the memory
// read-modify-write. Estimate sweeps the 2^b active registers, then runs
// the bit-serial divider, then rounds and outputs; clear sweeps all
// 2^MAX_BUCKET_BITS registers. After reset the memory is swept to zero,
// during which no item is accepted (configuration writes are). A result
// waits in the output register while the next item is already accepted;
// the block stalls only when a second result is ready.
module hyperloglog_sketch
    import hll_pkg::*;
#(
    parameter int MAX_BUCKET_BITS = 12
) (
    input  logic i_clk,
    input  logic i_rst_n,
    hll_cfg_if.sink      i_cfg,
    hll_item_if.sink     i_item,
    hll_result_if.source o_result
);

    localparam int AW    = MAX_BUCKET_BITS;
    localparam int DEPTH = 1 << AW;
    localparam int SUM_W = FRAC_BITS + AW + 1;
    localparam int N_W   = ALPHA_W + 2 * AW + 52;
    localparam int NCW   = $clog2(N_W + 1);
    localparam int CW    = (AW + 1 > NCW) ? AW + 1 : NCW;

    // Configuration registers.
    logic [3:0]  r_bucket_bits;
    logic [31:0] r_seed;
    logic [6:0]  r_offset;

    // Control.
    t_state        r_state, n_state;
    t_cmd          r_cmd;
    logic [1:0]    r_mphase;
    logic [1:0]    r_mstep;
    logic [2:0]    r_byte;
    logic [CW-1:0] r_cnt;
    logic          r_pv;
    logic          r_clr_out;
    logic          r_ov;

    // Datapath.
    logic [63:0]      r_x;
    logic [63:0]      r_acc;
    logic [63:0]      r_sh;
    logic             r_hzero;
    logic [6:0]       r_lz;
    logic [7:0]       r_rank;
    logic [AW-1:0]    r_addr;
    logic [7:0]       r_data;
    logic [7:0]       r_clrval;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] r_rem;
    logic [N_W-1:0]   r_num;
    logic [63:0]      r_q;
    logic             r_qovf;
    logic [7:0]       r_res_rd;
    logic [63:0]      r_res_est;
    logic [7:0]       r_out_rd;
    logic [63:0]      r_out_est;
    logic [12:0]      r_out_cnt;

    // Register memory.
    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rdata;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;

    function automatic logic [3:0] lz8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd8;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                n = 4'(7 - i);
            end
        end
        return n;
    endfunction

    // Effective bucket bits, clamped to the supported range.
    logic [4:0]    eff_b;
    logic [CW-1:0] m_cnt;
    logic [AW-1:0] idx_mask;
    always_comb begin
        if (r_bucket_bits < 4'(MIN_BITS)) begin
            eff_b = 5'(MIN_BITS);
        end else if (5'(r_bucket_bits) > 5'(AW)) begin
            eff_b = 5'(AW);
        end else begin
            eff_b = 5'(r_bucket_bits);
        end
        m_cnt    = CW'(1) << eff_b;
        idx_mask = AW'(m_cnt - CW'(1));
    end

    // Configuration port, always ready.
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_bits <= 4'd12;
            r_seed        <= '0;
            r_offset      <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_BUCKET_BITS: r_bucket_bits <= i_cfg.data[3:0];
                CFG_HASH_SEED:   r_seed        <= i_cfg.data;
                CFG_RANK_OFFSET: r_offset      <= i_cfg.data[6:0];
                default: ;
            endcase
        end
    end

    logic in_acc;
    logic out_ld;
    assign i_item.ready = (r_state == S_IDLE);
    assign in_acc       = i_item.valid && i_item.ready;
    assign out_ld       = (r_state == S_DONE) && (!r_ov || o_result.ready);

    // Shared 32x32 multiplier for the hash. A 64-bit product keeps its low
    // 64 bits: lo*lo, then the two cross terms shifted up by 32.
    logic [31:0] mul_a, mul_c;
    logic [63:0] mul_p;
    logic [63:0] mul_res;
    always_comb begin
        unique case (r_mstep)
            2'd0:    begin mul_a = r_x[31:0];  mul_c = MIX_MUL[31:0];  end
            2'd1:    begin mul_a = r_x[31:0];  mul_c = MIX_MUL[63:32]; end
            default: begin mul_a = r_x[63:32]; mul_c = MIX_MUL[31:0];  end
        endcase
        mul_p   = 64'(mul_a) * 64'(mul_c);
        mul_res = r_acc + {mul_p[31:0], 32'd0};
    end

    logic [63:0] hash_fin;
    assign hash_fin = mul_res ^ (mul_res >> MIX_SHIFT);

    // Bucket index: the top eff_b bits of the finished hash.
    logic [AW-1:0] bucket;
    assign bucket = hash_fin[63 -: AW] >> (5'(AW) - eff_b);

    // Leading-zero scan, one byte per cycle.
    logic [7:0] top_byte;
    logic       lz_done;
    logic [7:0] rank;
    assign top_byte = r_sh[63:56];
    assign lz_done  = (top_byte != 8'd0) || (r_byte == 3'd7);
    always_comb begin
        if (r_hzero) begin
            rank = 8'd0;
        end else if (top_byte == 8'd0) begin
            rank = 8'(r_offset) + 8'd65 - 8'(eff_b);
        end else begin
            rank = 8'(r_offset) + 8'd1 + 8'(r_lz) + 8'(lz8(top_byte));
        end
    end

    // Updated register value for the read-modify-write commands.
    logic [7:0] mod_val;
    always_comb begin
        unique case (r_cmd)
            CMD_ADD:   mod_val = (r_rank > r_rdata) ? r_rank : r_rdata;
            CMD_MERGE: mod_val = (r_data > r_rdata) ? r_data : r_rdata;
            CMD_WRITE: mod_val = r_data;
            default:   mod_val = r_rdata;
        endcase
    end

    // Estimate term 2^-(reg - offset) with 72 fractional bits; a register
    // below the offset counts as 1, and a term below 2^-72 is dropped.
    logic [8:0]       diff;
    logic [6:0]       dexp;
    logic             term_skip;
    logic [SUM_W-1:0] term;
    always_comb begin
        diff      = {1'b0, r_rdata} - {2'b00, r_offset};
        dexp      = diff[8] ? 7'd0 : diff[6:0];
        term_skip = !diff[8] && (diff[7] || diff[6:0] > 7'(FRAC_BITS));
        term      = term_skip ? '0 : (SUM_W'(1) << (7'(FRAC_BITS) - dexp));
    end

    // One restoring division step.
    logic [SUM_W:0] div_t;
    logic           div_ge;
    assign div_t  = {r_rem, r_num[N_W-1]};
    assign div_ge = div_t >= {1'b0, r_sum};

    // Memory ports.
    assign rd_addr = (r_state == S_SUM) ? r_cnt[AW-1:0] : r_addr;
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = mod_val;
        if (r_state == S_MOD && r_cmd != CMD_READ) begin
            mem_we = 1'b1;
        end else if (r_state == S_CLR) begin
            mem_we    = 1'b1;
            mem_waddr = r_cnt[AW-1:0];
            mem_wdata = r_clrval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_item.cmd)
                        CMD_ADD:                       n_state = S_HASH;
                        CMD_MERGE, CMD_WRITE, CMD_READ: n_state = S_READ;
                        CMD_ESTIMATE:                  n_state = S_SUM;
                        CMD_CLEAR:                     n_state = S_CLR;
                        default:                       n_state = S_DONE;
                    endcase
                end
            end
            S_HASH: begin
                if (r_mstep == 2'd2 && r_mphase == 2'd3) begin
                    n_state = S_LZ;
                end
            end
            S_LZ: begin
                if (lz_done) begin
                    n_state = S_MOD;
                end
            end
            S_READ: n_state = S_MOD;
            S_MOD:  n_state = S_DONE;
            S_SUM: begin
                if (r_cnt == m_cnt && !r_pv) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == CW'(N_W - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: n_state = S_DONE;
            S_CLR: begin
                if (r_cnt == CW'(DEPTH - 1)) begin
                    n_state = r_clr_out ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (out_ld) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_clr_out <= 1'b0;
            r_clrval  <= '0;
            r_ov      <= 1'b0;
            r_mphase  <= '0;
            r_mstep   <= '0;
            r_byte    <= '0;
            r_pv      <= 1'b0;
        end else begin
            if (out_ld) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd     <= t_cmd'(i_item.cmd);
                        r_x       <= i_item.item_value;
                        r_addr    <= AW'({{AW{1'b0}}, i_item.entry_index}) & idx_mask;
                        r_data    <= i_item.entry_data;
                        r_mphase  <= '0;
                        r_mstep   <= '0;
                        r_cnt     <= '0;
                        r_pv      <= 1'b0;
                        r_sum     <= '0;
                        r_clrval  <= 8'(r_offset);
                        r_clr_out <= 1'b1;
                        r_res_rd  <= '0;
                        r_res_est <= '0;
                    end
                end
                S_HASH: begin
                    if (r_mstep == 2'd0) begin
                        r_acc   <= mul_p;
                        r_mstep <= 2'd1;
                    end else if (r_mstep == 2'd1) begin
                        r_acc   <= mul_res;
                        r_mstep <= 2'd2;
                    end else begin
                        r_mstep  <= 2'd0;
                        r_mphase <= r_mphase + 2'd1;
                        unique case (r_mphase)
                            2'd0:    r_x <= mul_res ^ (mul_res >> MIX_SHIFT);
                            2'd1:    r_x <= MIX_KEY8 ^ 64'(r_seed) ^ mul_res;
                            2'd2:    r_x <= mul_res ^ (mul_res >> MIX_SHIFT);
                            default: begin
                                // Hash done: start the scan over the bits
                                // below the bucket index.
                                r_hzero <= (hash_fin == 64'd0);
                                r_sh    <= hash_fin << eff_b;
                                r_addr  <= bucket;
                                r_lz    <= '0;
                                r_byte  <= '0;
                            end
                        endcase
                    end
                end
                S_LZ: begin
                    r_sh   <= r_sh << 8;
                    r_lz   <= r_lz + 7'd8;
                    r_byte <= r_byte + 3'd1;
                    if (lz_done) begin
                        r_rank <= rank;
                    end
                end
                S_MOD: begin
                    r_res_rd <= mod_val;
                end
                S_SUM: begin
                    if (r_pv) begin
                        r_sum <= r_sum + term;
                    end
                    if (r_cnt != m_cnt) begin
                        r_cnt <= r_cnt + CW'(1);
                        r_pv  <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            // Numerator alpha * m * m * 2^52.
                            r_num  <= N_W'(alpha_q20(eff_b)) << (7'(2 * eff_b) + 7'd52);
                            r_rem  <= '0;
                            r_q    <= '0;
                            r_qovf <= (r_sum == '0);
                            r_cnt  <= '0;
                        end
                    end
                end
                S_DIV: begin
                    r_num  <= r_num << 1;
                    r_rem  <= div_ge ? SUM_W'(div_t - {1'b0, r_sum}) : SUM_W'(div_t);
                    r_q    <= {r_q[62:0], div_ge};
                    r_qovf <= r_qovf | r_q[63];
                    r_cnt  <= r_cnt + CW'(1);
                end
                S_FIN: begin
                    r_res_est <= (r_qovf || (&r_q)) ? '1 : r_q + 64'd1;
                end
                S_CLR: begin
                    r_cnt <= r_cnt + CW'(1);
                end
                S_DONE: begin
                    if (out_ld) begin
                        r_out_rd  <= r_res_rd;
                        r_out_est <= r_res_est;
                        r_out_cnt <= 13'(m_cnt);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_result.valid       = r_ov;
    assign o_result.read_data   = r_out_rd;
    assign o_result.estimate    = r_out_est;
    assign o_result.entry_count = r_out_cnt;

endmodule
